// File: rtl/tsd_pkg.sv
// Shared constants, codes and word layouts for the transaction slot dispatcher.
package tsd_pkg;

  // Slot table sizes
  localparam int CLIENT_SLOTS = 8;
  localparam int SERVER_SLOTS = 8;

  localparam int CIDX_W = (CLIENT_SLOTS > 1) ? $clog2(CLIENT_SLOTS) : 1;
  localparam int SIDX_W = (SERVER_SLOTS > 1) ? $clog2(SERVER_SLOTS) : 1;
  localparam int SCAN_W = (CIDX_W > SIDX_W) ? CIDX_W : SIDX_W;

  // Field widths
  localparam int OP_W    = 2;
  localparam int PDU_W   = 3;
  localparam int ID_W    = 8;
  localparam int PEER_W  = 48;
  localparam int SLOT_W  = 3;
  localparam int KIND_W  = 2;

  localparam int IN_DATA_W  = 64;
  localparam int OUT_DATA_W = 16;

  // Item operations
  localparam logic [OP_W-1:0] OP_DELIVER    = 2'd0;
  localparam logic [OP_W-1:0] OP_ALLOCATE   = 2'd1;
  localparam logic [OP_W-1:0] OP_SET_CLIENT = 2'd2;
  localparam logic [OP_W-1:0] OP_SET_SERVER = 2'd3;

  // Decoded PDU types
  localparam logic [PDU_W-1:0] PDU_CONF_REQ    = 3'd0;
  localparam logic [PDU_W-1:0] PDU_UNCONF_REQ  = 3'd1;
  localparam logic [PDU_W-1:0] PDU_SIMPLE_ACK  = 3'd2;
  localparam logic [PDU_W-1:0] PDU_COMPLEX_ACK = 3'd3;
  localparam logic [PDU_W-1:0] PDU_SEGMENT_ACK = 3'd4;
  localparam logic [PDU_W-1:0] PDU_ERROR       = 3'd5;
  localparam logic [PDU_W-1:0] PDU_REJECT      = 3'd6;
  localparam logic [PDU_W-1:0] PDU_ABORT       = 3'd7;

  // Result target kinds
  localparam logic [KIND_W-1:0] KIND_NONE   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_CLIENT = 2'd1;
  localparam logic [KIND_W-1:0] KIND_SERVER = 2'd2;

  // Reset value of the invoke ID counter
  localparam logic [ID_W-1:0] FIRST_INVOKE = 8'd1;

endpackage

// File: rtl/transaction_slot_dispatcher.sv
// Transaction slot dispatcher: routes PDUs to client/server slots, hands out invoke IDs.
//
//  channel | dir | word layout (low bit up)
//  --------+-----+---------------------------------------------------------------
//  in_     | in  | tuser: op[1:0]; tdata: pdu_type, invoke_id, peer_addr,
//          |     |   from_server, slot_index, busy_flag
//  out_    | out | tuser: target_kind[1:0]; tdata: target_slot, newly_bound,
//          |     |   new_invoke_id, zero pad
//
//  A set-slot item goes from accept through the reply state to the output
//  register. A deliver item uses one shared tag comparator that walks the slot
//  table one entry a cycle and stops at the first hit. An allocate item makes
//  one client walk per candidate ID.
//  Reset clears all slot marks and sets the ID counter to 1 in the same cycle.
//  in_tready is low while an item is in work; a result that waits in the output
//  register does not stall the walk, only the hand-off of the next result.
module transaction_slot_dispatcher (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // pdu_type[2:0], invoke_id[10:3], peer_addr[58:11], from_server[59],
  // slot_index[62:60], busy_flag[63]
  input  logic [tsd_pkg::IN_DATA_W-1:0]   in_tdata,
  // op[1:0]
  input  logic [tsd_pkg::OP_W-1:0]        in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // target_slot[2:0], newly_bound[3], new_invoke_id[11:4], zero[15:12]
  output logic [tsd_pkg::OUT_DATA_W-1:0]  out_tdata,
  // target_kind[1:0]
  output logic [tsd_pkg::KIND_W-1:0]      out_tuser
);
  import tsd_pkg::*;

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_REPLY} state_t;

  // what the walk is looking for
  typedef enum logic [2:0] {
    M_CONF,     // busy server with tag, remembering first idle server
    M_UNCONF,   // first idle server
    M_SRV_ANY,  // any server with tag
    M_CLIENT,   // busy client with invoke ID
    M_ALLOC     // busy client holding the candidate ID
  } mode_t;

  // unpacked input word
  logic [PDU_W-1:0]  in_pdu;
  logic [ID_W-1:0]   in_id;
  logic [PEER_W-1:0] in_peer;
  logic              in_from_srv;
  logic [SLOT_W-1:0] in_slot;
  logic              in_busy;

  assign in_pdu      = in_tdata[2:0];
  assign in_id       = in_tdata[10:3];
  assign in_peer     = in_tdata[58:11];
  assign in_from_srv = in_tdata[59];
  assign in_slot     = in_tdata[62:60];
  assign in_busy     = in_tdata[63];

  // slot table
  logic              client_busy_r   [CLIENT_SLOTS];
  logic              client_busy_nxt [CLIENT_SLOTS];
  logic [ID_W-1:0]   client_inv_r    [CLIENT_SLOTS];
  logic [ID_W-1:0]   client_inv_nxt  [CLIENT_SLOTS];
  logic              server_busy_r   [SERVER_SLOTS];
  logic              server_busy_nxt [SERVER_SLOTS];
  logic [ID_W-1:0]   server_inv_r    [SERVER_SLOTS];
  logic [ID_W-1:0]   server_inv_nxt  [SERVER_SLOTS];
  logic [PEER_W-1:0] server_peer_r   [SERVER_SLOTS];
  logic [PEER_W-1:0] server_peer_nxt [SERVER_SLOTS];
  logic [ID_W-1:0]   next_inv_r, next_inv_nxt;

  // sequencer and item context
  state_t            state_r, state_nxt;
  mode_t             mode_r, mode_nxt;
  logic [SCAN_W-1:0] cnt_r, cnt_nxt;
  logic [ID_W-1:0]   key_id_r, key_id_nxt;
  logic [PEER_W-1:0] key_peer_r, key_peer_nxt;
  logic              idle_found_r, idle_found_nxt;
  logic [SCAN_W-1:0] idle_idx_r, idle_idx_nxt;

  // pending result
  logic [KIND_W-1:0] res_kind_r, res_kind_nxt;
  logic [SLOT_W-1:0] res_slot_r, res_slot_nxt;
  logic              res_bound_r, res_bound_nxt;
  logic [ID_W-1:0]   res_newid_r, res_newid_nxt;

  // output register
  logic                  out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;
  logic [KIND_W-1:0]     out_kind_r, out_kind_nxt;

  logic in_acc;
  assign in_tready  = (state_r == ST_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_kind_r;

  // shared tag comparator on the entry under the walk pointer
  logic [CIDX_W-1:0]      cidx;
  logic [SIDX_W-1:0]      sidx;
  logic                   use_client;
  logic [ID_W+PEER_W-1:0] slot_tag, key_tag;
  logic                   tag_eq, slot_busy, hit, last;
  logic [ID_W-1:0]        cmp_id;

  assign cidx       = CIDX_W'(cnt_r);
  assign sidx       = SIDX_W'(cnt_r);
  assign use_client = (mode_r == M_CLIENT) || (mode_r == M_ALLOC);
  assign cmp_id     = (mode_r == M_ALLOC) ? next_inv_r : key_id_r;
  assign slot_tag   = use_client ? {client_inv_r[cidx], {PEER_W{1'b0}}}
                                 : {server_inv_r[sidx], server_peer_r[sidx]};
  assign key_tag    = {cmp_id, use_client ? {PEER_W{1'b0}} : key_peer_r};
  assign tag_eq     = (slot_tag == key_tag);
  assign slot_busy  = use_client ? client_busy_r[cidx] : server_busy_r[sidx];
  assign last       = use_client ? (cnt_r == SCAN_W'(CLIENT_SLOTS - 1))
                                 : (cnt_r == SCAN_W'(SERVER_SLOTS - 1));

  always_comb begin
    case (mode_r)
      M_CONF:    hit = slot_busy && tag_eq;
      M_UNCONF:  hit = !slot_busy;
      M_SRV_ANY: hit = tag_eq;
      M_CLIENT:  hit = slot_busy && tag_eq;
      M_ALLOC:   hit = slot_busy && tag_eq;
      default:   hit = 1'b0;
    endcase
  end

  // next-state logic
  always_comb begin
    client_busy_nxt = client_busy_r;
    client_inv_nxt  = client_inv_r;
    server_busy_nxt = server_busy_r;
    server_inv_nxt  = server_inv_r;
    server_peer_nxt = server_peer_r;
    next_inv_nxt    = next_inv_r;
    state_nxt       = state_r;
    mode_nxt        = mode_r;
    cnt_nxt         = cnt_r;
    key_id_nxt      = key_id_r;
    key_peer_nxt    = key_peer_r;
    idle_found_nxt  = idle_found_r;
    idle_idx_nxt    = idle_idx_r;
    res_kind_nxt    = res_kind_r;
    res_slot_nxt    = res_slot_r;
    res_bound_nxt   = res_bound_r;
    res_newid_nxt   = res_newid_r;
    out_valid_nxt   = out_valid_r && !out_tready;
    out_data_nxt    = out_data_r;
    out_kind_nxt    = out_kind_r;

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          key_id_nxt     = in_id;
          key_peer_nxt   = in_peer;
          cnt_nxt        = '0;
          idle_found_nxt = 1'b0;
          res_kind_nxt   = KIND_NONE;
          res_slot_nxt   = '0;
          res_bound_nxt  = 1'b0;
          res_newid_nxt  = '0;
          case (in_tuser)
            OP_DELIVER: begin
              state_nxt = ST_SCAN;
              case (in_pdu)
                PDU_CONF_REQ:   mode_nxt = M_CONF;
                PDU_UNCONF_REQ: mode_nxt = M_UNCONF;
                PDU_SEGMENT_ACK, PDU_ABORT:
                  mode_nxt = in_from_srv ? M_CLIENT : M_SRV_ANY;
                default:        mode_nxt = M_CLIENT;
              endcase
            end
            OP_ALLOCATE: begin
              state_nxt = ST_SCAN;
              mode_nxt  = M_ALLOC;
            end
            OP_SET_CLIENT: begin
              state_nxt = ST_REPLY;
              if (int'(in_slot) < CLIENT_SLOTS) begin
                client_busy_nxt[CIDX_W'(in_slot)] = in_busy;
                client_inv_nxt[CIDX_W'(in_slot)]  = in_id;
              end
            end
            default: begin
              state_nxt = ST_REPLY;
              if (int'(in_slot) < SERVER_SLOTS) begin
                server_busy_nxt[SIDX_W'(in_slot)] = in_busy;
                server_inv_nxt[SIDX_W'(in_slot)]  = in_id;
                server_peer_nxt[SIDX_W'(in_slot)] = in_peer;
              end
            end
          endcase
        end
      end

      ST_SCAN: begin
        cnt_nxt = cnt_r + 1'b1;
        case (mode_r)
          M_CONF: begin
            if (hit) begin
              res_kind_nxt = KIND_SERVER;
              res_slot_nxt = SLOT_W'(cnt_r);
              state_nxt    = ST_REPLY;
            end else begin
              if (!slot_busy && !idle_found_r) begin
                idle_found_nxt = 1'b1;
                idle_idx_nxt   = cnt_r;
              end
              // end of walk: bind the first idle server, if any
              if (last) begin
                state_nxt = ST_REPLY;
                if (idle_found_r || !slot_busy) begin
                  res_kind_nxt  = KIND_SERVER;
                  res_bound_nxt = 1'b1;
                  if (idle_found_r) begin
                    res_slot_nxt = SLOT_W'(idle_idx_r);
                    server_inv_nxt[SIDX_W'(idle_idx_r)]  = key_id_r;
                    server_peer_nxt[SIDX_W'(idle_idx_r)] = key_peer_r;
                  end else begin
                    res_slot_nxt = SLOT_W'(cnt_r);
                    server_inv_nxt[sidx]  = key_id_r;
                    server_peer_nxt[sidx] = key_peer_r;
                  end
                end
              end
            end
          end
          M_UNCONF: begin
            if (hit) begin
              server_peer_nxt[sidx] = key_peer_r;
              res_kind_nxt  = KIND_SERVER;
              res_slot_nxt  = SLOT_W'(cnt_r);
              res_bound_nxt = 1'b1;
              state_nxt     = ST_REPLY;
            end else if (last) begin
              state_nxt = ST_REPLY;
            end
          end
          M_ALLOC: begin
            // each try consumes the candidate; a hit restarts the walk
            if (hit || last) begin
              next_inv_nxt = next_inv_r + 1'b1;
              if (hit) begin
                cnt_nxt = '0;
              end else begin
                res_newid_nxt = next_inv_r;
                state_nxt     = ST_REPLY;
              end
            end
          end
          default: begin
            if (hit) begin
              res_kind_nxt = (mode_r == M_CLIENT) ? KIND_CLIENT : KIND_SERVER;
              res_slot_nxt = SLOT_W'(cnt_r);
              state_nxt    = ST_REPLY;
            end else if (last) begin
              state_nxt = ST_REPLY;
            end
          end
        endcase
      end

      ST_REPLY: begin
        // hand the result to the output register once it is free
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = res_kind_r;
          out_data_nxt  = {4'b0000, res_newid_r, res_bound_r, res_slot_r};
          state_nxt     = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_valid_r  <= 1'b0;
      next_inv_r   <= FIRST_INVOKE;
      idle_found_r <= 1'b0;
      for (int i = 0; i < CLIENT_SLOTS; i++) begin
        client_busy_r[i] <= 1'b0;
        client_inv_r[i]  <= '0;
      end
      for (int i = 0; i < SERVER_SLOTS; i++) begin
        server_busy_r[i] <= 1'b0;
        server_inv_r[i]  <= '0;
        server_peer_r[i] <= '0;
      end
    end else begin
      state_r       <= state_nxt;
      out_valid_r   <= out_valid_nxt;
      next_inv_r    <= next_inv_nxt;
      idle_found_r  <= idle_found_nxt;
      client_busy_r <= client_busy_nxt;
      client_inv_r  <= client_inv_nxt;
      server_busy_r <= server_busy_nxt;
      server_inv_r  <= server_inv_nxt;
      server_peer_r <= server_peer_nxt;
    end
    mode_r      <= mode_nxt;
    cnt_r       <= cnt_nxt;
    key_id_r    <= key_id_nxt;
    key_peer_r  <= key_peer_nxt;
    idle_idx_r  <= idle_idx_nxt;
    res_kind_r  <= res_kind_nxt;
    res_slot_r  <= res_slot_nxt;
    res_bound_r <= res_bound_nxt;
    res_newid_r <= res_newid_nxt;
    out_data_r  <= out_data_nxt;
    out_kind_r  <= out_kind_nxt;
  end

endmodule

// File: rtl/tsd_checker.sv
// Port-level checks for the transaction slot dispatcher, bound to the top level.
module tsd_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [tsd_pkg::OUT_DATA_W-1:0]  out_tdata,
  input logic [tsd_pkg::KIND_W-1:0]      out_tuser
);
  import tsd_pkg::*;

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result word changed while stalled");

  // one item at a time: busy right after an accept
  a_busy_after_acc: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted while an item is in work");

  // binding only ever names a server slot
  a_bound_server: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[3] |-> out_tuser == KIND_SERVER)
    else $error("newly bound result without server target");

  // an issued ID comes only with an empty routing part
  a_newid_alone: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[11:4] != '0) |->
      out_tuser == KIND_NONE && out_tdata[3:0] == '0)
    else $error("invoke ID issued together with a routing target");

  // no routing code beyond server
  a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tuser == KIND_NONE || out_tuser == KIND_CLIENT ||
      out_tuser == KIND_SERVER)
    else $error("undefined target kind");

endmodule

bind transaction_slot_dispatcher tsd_checker u_tsd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

// File: tb/sv/transaction_slot_dispatcher_test.sv
// Self-checking stream testbench for the transaction slot dispatcher.
`timescale 1ns / 100ps

module transaction_slot_dispatcher_test;
  import tsd_pkg::*;

  localparam int ID_SPACE = 1 << ID_W;

  // One input word, split into its fields
  typedef struct {
    logic [OP_W-1:0]   op;
    logic [PDU_W-1:0]  pdu;
    logic [ID_W-1:0]   id;
    logic [PEER_W-1:0] peer;
    logic              from_srv;
    logic [SLOT_W-1:0] idx;
    logic              busy;
  } dispatch_word_t;

  // One routing result
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [SLOT_W-1:0] slot;
    logic              bound;
    logic [ID_W-1:0]   new_id;
  } route_result_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic [OP_W-1:0]       in_tuser = OP_DELIVER;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [KIND_W-1:0]     out_tuser;

  // Predicted slot tables and invoke ID counter
  logic              cl_busy   [CLIENT_SLOTS] = '{default: 1'b0};
  logic [ID_W-1:0]   cl_invoke [CLIENT_SLOTS] = '{default: '0};
  logic              sv_busy   [SERVER_SLOTS] = '{default: 1'b0};
  logic [ID_W-1:0]   sv_invoke [SERVER_SLOTS] = '{default: '0};
  logic [PEER_W-1:0] sv_peer   [SERVER_SLOTS] = '{default: '0};
  logic [ID_W-1:0]   invoke_ctr = FIRST_INVOKE;

  route_result_t pending_routes[$];
  int            mismatch_count = 0;

  // Idle rates in percent, and long output hold-off requested by the tests
  int send_gap_pct = 0;
  int recv_stall_pct = 0;
  int long_stall_cycles = 0;
  int stall_run = 0;

  transaction_slot_dispatcher dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Slot table searches, lowest index first
  function automatic int find_busy_client(input logic [ID_W-1:0] id);
    for (int i = 0; i < CLIENT_SLOTS; i++)
      if (cl_busy[i] && cl_invoke[i] == id) return i;
    return -1;
  endfunction

  function automatic int find_idle_server();
    for (int i = 0; i < SERVER_SLOTS; i++)
      if (!sv_busy[i]) return i;
    return -1;
  endfunction

  function automatic int find_server(input logic [ID_W-1:0] id, input logic [PEER_W-1:0] peer,
                                     input logic need_busy);
    for (int i = 0; i < SERVER_SLOTS; i++)
      if ((!need_busy || sv_busy[i]) && sv_invoke[i] == id && sv_peer[i] == peer) return i;
    return -1;
  endfunction

  // Updates the predicted tables for one word and returns its routing result
  function automatic route_result_t predict_dispatch(input dispatch_word_t w);
    route_result_t r;
    int s;
    r = '0;
    case (w.op)
      OP_DELIVER: begin
        if (w.pdu == PDU_CONF_REQ) begin
          s = find_server(w.id, w.peer, 1'b1);
          if (s >= 0) begin
            r.kind = KIND_SERVER;
            r.slot = s[SLOT_W-1:0];
          end else begin
            // bind the lowest idle server; busy mark stays as is
            s = find_idle_server();
            if (s >= 0) begin
              sv_invoke[SIDX_W'(s)] = w.id;
              sv_peer[SIDX_W'(s)] = w.peer;
              r.kind = KIND_SERVER;
              r.slot = s[SLOT_W-1:0];
              r.bound = 1'b1;
            end
          end
        end else if (w.pdu == PDU_UNCONF_REQ) begin
          s = find_idle_server();
          if (s >= 0) begin
            sv_peer[SIDX_W'(s)] = w.peer;
            r.kind = KIND_SERVER;
            r.slot = s[SLOT_W-1:0];
            r.bound = 1'b1;
          end
        end else if ((w.pdu == PDU_SEGMENT_ACK || w.pdu == PDU_ABORT) && !w.from_srv) begin
          // from a client: any server with matching ID and peer
          s = find_server(w.id, w.peer, 1'b0);
          if (s >= 0) begin
            r.kind = KIND_SERVER;
            r.slot = s[SLOT_W-1:0];
          end
        end else begin
          s = find_busy_client(w.id);
          if (s >= 0) begin
            r.kind = KIND_CLIENT;
            r.slot = s[SLOT_W-1:0];
          end
        end
      end
      OP_ALLOCATE: begin
        // skip IDs held by busy clients
        for (int t = 0; t < ID_SPACE; t++) begin
          r.new_id = invoke_ctr;
          invoke_ctr = invoke_ctr + 1'b1;
          if (find_busy_client(r.new_id) < 0) break;
        end
      end
      OP_SET_CLIENT: begin
        if (w.idx < CLIENT_SLOTS) begin
          cl_busy[CIDX_W'(w.idx)] = w.busy;
          cl_invoke[CIDX_W'(w.idx)] = w.id;
        end
      end
      default: begin
        if (w.idx < SERVER_SLOTS) begin
          sv_busy[SIDX_W'(w.idx)] = w.busy;
          sv_invoke[SIDX_W'(w.idx)] = w.id;
          sv_peer[SIDX_W'(w.idx)] = w.peer;
        end
      end
    endcase
    return r;
  endfunction

  function automatic dispatch_word_t make_word(input logic [OP_W-1:0] op,
      input logic [PDU_W-1:0] pdu, input logic [ID_W-1:0] id, input logic [PEER_W-1:0] peer,
      input logic from_srv, input logic [SLOT_W-1:0] idx, input logic busy);
    dispatch_word_t w;
    w.op = op;
    w.pdu = pdu;
    w.id = id;
    w.peer = peer;
    w.from_srv = from_srv;
    w.idx = idx;
    w.busy = busy;
    return w;
  endfunction

  // Offer one word, wait for the handshake, then record its expected result
  task automatic send_word(input dispatch_word_t w);
    while ($urandom_range(99) < send_gap_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= w.op;
    in_tdata <= {w.busy, w.idx, w.from_srv, w.peer, w.id, w.pdu};
    do @(posedge clk); while (!in_tready);
    pending_routes.push_back(predict_dispatch(w));
  endtask

  // Drop valid and wait for every outstanding result
  task automatic wait_for_results();
    in_tvalid <= 1'b0;
    while (pending_routes.size() != 0) @(posedge clk);
  endtask

  // Output ready: random stalls, plus long hold-offs on request
  always @(posedge clk) begin
    if (stall_run < long_stall_cycles) begin
      out_tready <= 1'b0;
      stall_run <= stall_run + 1;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic report_field(input string what, input logic [15:0] want,
                              input logic [15:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, what, want, got);
      mismatch_count++;
    end
  endtask

  // Compare each result word with the oldest expectation
  always @(posedge clk) begin : result_check
    route_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_routes.size() == 0) begin
        $display("%0t: unexpected result word, expected none actual %0h/%0h",
                 $time, out_tuser, out_tdata);
        mismatch_count++;
      end else begin
        want = pending_routes.pop_front();
        report_field("target_kind", 16'(want.kind), 16'(out_tuser));
        report_field("target_slot", 16'(want.slot), 16'(out_tdata[2:0]));
        report_field("newly_bound", 16'(want.bound), 16'(out_tdata[3]));
        report_field("new_invoke_id", 16'(want.new_id), 16'(out_tdata[11:4]));
        report_field("pad", '0, 16'(out_tdata[15:12]));
      end
    end
  end

  // Each operation, each PDU route and the table corner cases
  task automatic test_directed_cases();
    send_word(make_word(OP_ALLOCATE, PDU_CONF_REQ, 8'd0, '0, 1'b0, 3'd0, 1'b0));
    send_word(make_word(OP_SET_CLIENT, PDU_CONF_REQ, 8'd2, '1, 1'b0, 3'd0, 1'b1));
    send_word(make_word(OP_SET_CLIENT, PDU_CONF_REQ, 8'd255, '0, 1'b0, 3'd7, 1'b1));
    // next ID is held by a busy client and gets skipped
    send_word(make_word(OP_ALLOCATE, PDU_CONF_REQ, 8'd0, '0, 1'b0, 3'd0, 1'b0));
    send_word(make_word(OP_DELIVER, PDU_SIMPLE_ACK, 8'd2, '0, 1'b0, 3'd0, 1'b0));
    send_word(make_word(OP_DELIVER, PDU_COMPLEX_ACK, 8'd255, '1, 1'b1, 3'd7, 1'b1));
    send_word(make_word(OP_DELIVER, PDU_ERROR, 8'd0, '0, 1'b0, 3'd0, 1'b0));
    send_word(make_word(OP_DELIVER, PDU_REJECT, 8'd2, '0, 1'b0, 3'd0, 1'b0));
    // existing server transaction, then binding of an idle server
    send_word(make_word(OP_SET_SERVER, PDU_CONF_REQ, 8'd5, '1, 1'b0, 3'd0, 1'b1));
    send_word(make_word(OP_DELIVER, PDU_CONF_REQ, 8'd5, '1, 1'b0, 3'd0, 1'b0));
    send_word(make_word(OP_DELIVER, PDU_CONF_REQ, 8'd9, '0, 1'b0, 3'd0, 1'b0));
    send_word(make_word(OP_DELIVER, PDU_UNCONF_REQ, 8'd0, 48'h123, 1'b0, 3'd0, 1'b0));
    // segment ack and abort from both sides
    send_word(make_word(OP_DELIVER, PDU_SEGMENT_ACK, 8'd9, 48'h123, 1'b0, 3'd0, 1'b0));
    send_word(make_word(OP_DELIVER, PDU_ABORT, 8'd0, '0, 1'b0, 3'd0, 1'b0));
    send_word(make_word(OP_DELIVER, PDU_SEGMENT_ACK, 8'd255, '0, 1'b1, 3'd0, 1'b0));
    send_word(make_word(OP_DELIVER, PDU_ABORT, 8'd7, '0, 1'b1, 3'd0, 1'b0));
    // all servers busy: requests find no slot
    for (int i = 1; i < SERVER_SLOTS; i++)
      send_word(make_word(OP_SET_SERVER, PDU_CONF_REQ, 8'(i), 48'(i), 1'b0, SLOT_W'(i), 1'b1));
    send_word(make_word(OP_DELIVER, PDU_CONF_REQ, 8'd77, 48'h5, 1'b0, 3'd0, 1'b0));
    send_word(make_word(OP_DELIVER, PDU_UNCONF_REQ, 8'd0, 48'h5, 1'b0, 3'd0, 1'b0));
  endtask

  // Mixed traffic; IDs and peers mostly taken from the live tables so lookups hit
  task automatic test_random_traffic(input int count);
    dispatch_word_t w;
    int pick;
    repeat (count) begin
      pick = $urandom_range(99);
      w.op = (pick < 55) ? OP_DELIVER : (pick < 70) ? OP_ALLOCATE :
             (pick < 85) ? OP_SET_CLIENT : OP_SET_SERVER;
      w.pdu = PDU_W'($urandom_range(7));
      pick = $urandom_range(99);
      if (pick < 45) w.id = cl_invoke[CIDX_W'($urandom_range(CLIENT_SLOTS - 1))];
      else if (pick < 75) w.id = sv_invoke[SIDX_W'($urandom_range(SERVER_SLOTS - 1))];
      else w.id = ID_W'($urandom_range(255));
      // a client slot often takes the ID that was just handed out
      if (w.op == OP_SET_CLIENT && $urandom_range(1)) w.id = invoke_ctr - 1'b1;
      pick = $urandom_range(99);
      if (pick < 60) w.peer = sv_peer[SIDX_W'($urandom_range(SERVER_SLOTS - 1))];
      else if (pick < 80) w.peer = 48'($urandom_range(3));
      else w.peer = {16'($urandom), 32'($urandom)};
      w.from_srv = 1'($urandom_range(1));
      w.idx = SLOT_W'($urandom_range(7));
      w.busy = 1'($urandom_range(1));
      send_word(w);
    end
  endtask

  // Allocate until the ID counter wraps, with busy clients around the wrap point
  task automatic test_invoke_wrap();
    logic [ID_W-1:0] prev;
    send_word(make_word(OP_SET_CLIENT, PDU_CONF_REQ, 8'd0, '0, 1'b0, 3'd1, 1'b1));
    send_word(make_word(OP_SET_CLIENT, PDU_CONF_REQ, 8'd254, '0, 1'b0, 3'd2, 1'b1));
    send_word(make_word(OP_SET_CLIENT, PDU_CONF_REQ, 8'd255, '0, 1'b0, 3'd7, 1'b1));
    do begin
      prev = invoke_ctr;
      send_word(make_word(OP_ALLOCATE, PDU_CONF_REQ, 8'd0, '0, 1'b0, 3'd0, 1'b0));
    end while (invoke_ctr >= prev);
  endtask

  // Hold the output off long enough to stall the input, then drain
  task automatic test_output_stall();
    long_stall_cycles = long_stall_cycles + 400;
    test_random_traffic(30);
    wait_for_results();
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    send_gap_pct = 12;
    recv_stall_pct = 84;
    test_directed_cases();
    test_random_traffic(170);

    send_gap_pct = 84;
    recv_stall_pct = 12;
    test_invoke_wrap();
    test_random_traffic(170);

    send_gap_pct = 0;
    recv_stall_pct = 0;
    test_output_stall();
    test_random_traffic(170);

    wait_for_results();
    repeat (100) @(posedge clk);
    if (mismatch_count == 0 && pending_routes.size() == 0) begin
      $display("transaction_slot_dispatcher_test: PASS");
    end else begin
      $display("transaction_slot_dispatcher_test: FAIL");
    end
    $finish;
  end

  // Hang guard
  initial begin
    #10_000_000;
    $display("transaction_slot_dispatcher_test: FAIL");
    $finish;
  end

endmodule
